// File: sv/lfows_pkg.sv
// shared types, constants and the cosine table builder for the lfo waveform shaper
package lfows_pkg;

    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_W     = 16;
    localparam int FW_W      = CFG_W + PHASE_W - 8;
    localparam int COS_DEPTH = 1024;
    localparam int COS_AW    = $clog2(COS_DEPTH) + 1;
    localparam int COS_FRAC  = 30 - $clog2(COS_DEPTH);
    localparam int DIV_STEPS = 31;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [KIND_W-1:0] KIND_SINE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SAW_UP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SAW_DOWN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SQUARE   = 3'd4;

    localparam logic [CFG_W-1:0] CFG_RESET = 16'd1024;

    localparam longint unsigned ONE_CYCLE = 64'd1 << PHASE_W;
    localparam longint unsigned SAW_FRAC  = (ONE_CYCLE * 64'd8 + 64'd50) / 64'd100;
    localparam longint unsigned SQR_FRAC  = (ONE_CYCLE * 64'd3 + 64'd50) / 64'd100;
    localparam longint unsigned PI_Q30    = 64'd3373259426;

    typedef logic signed [32:0] val_t;
    localparam val_t Q30V = 33'sd1073741824;

    typedef enum logic [2:0] {
        MODE_DIRECT,
        MODE_LIN,
        MODE_EASE_UP,
        MODE_EASE_DN,
        MODE_SAW_UP,
        MODE_SINE
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        val_t              base;
        logic [PHASE_W-1:0] angle;
    } pass_t;

    typedef struct packed {
        pass_t             pass;
        logic [PHASE_W-1:0] num;
        logic [PHASE_W:0]   den;
    } job_t;

    typedef logic [30:0] cos_word_t;
    typedef cos_word_t cos_rom_t [0:COS_DEPTH];

    // shift and subtract quotient, used only while building the table
    function automatic longint unsigned long_div(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 0;
        r = 0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        int                i;
        int                n;
        for (i = 0; i <= COS_DEPTH; i++)
        begin
            x    = (PI_Q30 * longint'(i)) >> ($clog2(COS_DEPTH) + 1);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = 64'sd1 << 30;
            for (n = 1; n <= 12; n++)
            begin
                term = long_div((term * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
                if ((n & 1) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            if (sum > (64'sd1 << 30))
            begin
                sum = 64'sd1 << 30;
            end
            rom[i] = cos_word_t'(sum);
        end
        return rom;
    endfunction

endpackage

// File: sv/lfows_in_if.sv
// input channel: phase, kind and phase step with valid/ready
interface lfows_in_if import lfows_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [PHASE_W-1:0]        phase;
    logic [KIND_W-1:0]         kind;
    logic signed [PHASE_W-1:0] phase_step;

    modport source (output valid, output phase, output kind, output phase_step, input ready);
    modport sink (input valid, input phase, input kind, input phase_step, output ready);
endinterface

// File: sv/lfows_out_if.sv
// output channel: one sample with valid/ready
interface lfows_out_if import lfows_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// File: sv/lfows_front.sv
// front end: config register, edge width and classification of each item
module lfows_front import lfows_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    lfows_in_if.sink           in_ch,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               q_full,
    output logic               push,
    output job_t               push_job
);

    localparam logic [FW_W-1:0]    SAW_FRAC_W = FW_W'(SAW_FRAC);
    localparam logic [FW_W-1:0]    SQR_FRAC_W = FW_W'(SQR_FRAC);
    localparam logic [FW_W-1:0]    HALF_FW    = FW_W'(ONE_CYCLE >> 1);
    localparam logic [PHASE_W:0]   ONE_X      = (PHASE_W+1)'(ONE_CYCLE);
    localparam logic [PHASE_W:0]   HALF_X     = (PHASE_W+1)'(ONE_CYCLE >> 1);
    localparam logic [PHASE_W:0]   QTR_X      = (PHASE_W+1)'(ONE_CYCLE >> 2);
    localparam logic [PHASE_W:0]   TQTR_X     = (PHASE_W+1)'((ONE_CYCLE >> 2) * 3);
    localparam logic [PHASE_W-1:0] QTR_P      = PHASE_W'(ONE_CYCLE >> 2);

    logic [CFG_W-1:0]   floor_reg;
    logic               adv;
    logic [PHASE_W-1:0] mag_in;

    logic               v1_reg;
    logic [PHASE_W-1:0] p1_reg;
    logic [KIND_W-1:0]  k1_reg;
    logic [PHASE_W-1:0] mag1_reg;

    logic               v2_reg;
    logic [PHASE_W-1:0] p2_reg;
    logic [KIND_W-1:0]  k2_reg;
    logic [FW_W-1:0]    fw2_reg;
    logic [FW_W+7:0]    fw_prod;

    logic               v3_reg;
    logic [PHASE_W-1:0] p3_reg;
    logic [KIND_W-1:0]  k3_reg;
    logic [PHASE_W-1:0] w3_reg;
    logic [FW_W-1:0]    frac;
    logic [FW_W-1:0]    wmax;
    logic [PHASE_W-1:0] w_next;

    logic [PHASE_W:0]   p_x;
    logic [PHASE_W:0]   w_x;
    logic [PHASE_W:0]   one_mw;
    logic [PHASE_W:0]   half_mw;
    logic [PHASE_W:0]   half_pw;
    job_t               job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            floor_reg <= cfg_wr_data;
        end
    end

    assign adv         = !v3_reg || !q_full;
    assign in_ch.ready = adv;
    assign mag_in      = in_ch.phase_step[PHASE_W-1] ? (~in_ch.phase_step + 1'b1)
                                                     : in_ch.phase_step;
    assign fw_prod     = (FW_W+8)'(floor_reg) * (FW_W+8)'(mag1_reg);
    assign frac        = (k2_reg == KIND_SQUARE) ? SQR_FRAC_W : SAW_FRAC_W;
    assign wmax        = (fw2_reg > frac) ? fw2_reg : frac;
    assign w_next      = (wmax > HALF_FW) ? HALF_FW[PHASE_W-1:0] : wmax[PHASE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg   <= in_ch.phase;
            k1_reg   <= in_ch.kind;
            mag1_reg <= mag_in;
            p2_reg   <= p1_reg;
            k2_reg   <= k1_reg;
            fw2_reg  <= fw_prod[FW_W+7:8];
            p3_reg   <= p2_reg;
            k3_reg   <= k2_reg;
            w3_reg   <= w_next;
        end
    end

    assign p_x     = {1'b0, p3_reg};
    assign w_x     = {1'b0, w3_reg};
    assign one_mw  = ONE_X - w_x;
    assign half_mw = HALF_X - w_x;
    assign half_pw = HALF_X + w_x;

    always_comb
    begin
        job.pass.mode  = MODE_DIRECT;
        job.pass.base  = '0;
        job.pass.angle = p3_reg - QTR_P;
        job.num        = '0;
        job.den        = (PHASE_W+1)'(1);
        unique case (k3_reg)
            KIND_SINE:
            begin
                job.pass.mode = MODE_SINE;
            end
            KIND_TRIANGLE:
            begin
                priority if (p_x < QTR_X)
                begin
                    job.pass.base = val_t'(p_x);
                end
                else if (p_x < TQTR_X)
                begin
                    job.pass.base = val_t'(HALF_X) - val_t'(p_x);
                end
                else
                begin
                    job.pass.base = val_t'(p_x - ONE_X);
                end
            end
            KIND_SAW_UP:
            begin
                if (p_x < one_mw)
                begin
                    job.pass.base = val_t'(p_x >> 1) - Q30V;
                end
                else
                begin
                    job.pass.mode = MODE_SAW_UP;
                    job.pass.base = val_t'(one_mw >> 1) - Q30V;
                    job.num       = PHASE_W'(p_x - one_mw);
                    job.den       = w_x;
                end
            end
            KIND_SAW_DOWN:
            begin
                if (p_x < w_x)
                begin
                    job.pass.mode = MODE_EASE_UP;
                    job.pass.base = -Q30V;
                    job.num       = p3_reg;
                    job.den       = w_x;
                end
                else
                begin
                    job.pass.mode = MODE_LIN;
                    job.pass.base = Q30V;
                    job.num       = PHASE_W'(p_x - w_x);
                    job.den       = one_mw;
                end
            end
            KIND_SQUARE:
            begin
                priority if (p_x < half_mw)
                begin
                    job.pass.base = Q30V;
                end
                else if (p_x < half_pw)
                begin
                    job.pass.mode = MODE_EASE_DN;
                    job.pass.base = Q30V;
                    job.num       = PHASE_W'(p_x - half_mw);
                    job.den       = {w_x[PHASE_W-1:0], 1'b0};
                end
                else if (p_x < one_mw)
                begin
                    job.pass.base = -Q30V;
                end
                else
                begin
                    job.pass.mode = MODE_EASE_UP;
                    job.pass.base = -Q30V;
                    job.num       = PHASE_W'(p_x - one_mw);
                    job.den       = w_x;
                end
            end
            default:
            begin
                job.pass.base = '0;
            end
        endcase
    end

    assign push     = v3_reg && !q_full;
    assign push_job = job;

endmodule

// File: sv/lfows_queue.sv
// short fifo of classified items between front and back
module lfows_queue import lfows_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop && !empty})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: sv/lfows_div.sv
// pipelined restoring divider, one quotient bit per stage
module lfows_div import lfows_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  job_t                 in_job,
    output logic                 out_valid,
    output logic [DIV_STEPS-1:0] out_q,
    output pass_t                out_pass
);

    logic                 st_v [DIV_STEPS];
    logic [PHASE_W:0]     st_r [DIV_STEPS];
    logic [PHASE_W:0]     st_d [DIV_STEPS];
    logic [DIV_STEPS-1:0] st_q [DIV_STEPS];
    pass_t                st_p [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_step
        logic                 v_in;
        logic [PHASE_W:0]     r_in;
        logic [PHASE_W:0]     d_in;
        logic [DIV_STEPS-1:0] q_in;
        pass_t                p_in;
        logic [PHASE_W+1:0]   r2;
        logic                 ge;

        if (g == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = {1'b0, in_job.num};
            assign d_in = in_job.den;
            assign q_in = '0;
            assign p_in = in_job.pass;
        end
        else
        begin : g_next
            assign v_in = st_v[g-1];
            assign r_in = st_r[g-1];
            assign d_in = st_d[g-1];
            assign q_in = st_q[g-1];
            assign p_in = st_p[g-1];
        end

        assign r2 = {r_in, 1'b0};
        assign ge = (r2 >= {1'b0, d_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_v[g] <= 1'b0;
            end
            else if (adv)
            begin
                st_v[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_r[g] <= ge ? (PHASE_W+1)'(r2 - {1'b0, d_in}) : r2[PHASE_W:0];
                st_d[g] <= d_in;
                st_q[g] <= {q_in[DIV_STEPS-2:0], ge};
                st_p[g] <= p_in;
            end
        end
    end

    assign out_valid = st_v[DIV_STEPS-1] && (st_r[DIV_STEPS-1] <= st_d[DIV_STEPS-1]
                                             || st_v[DIV_STEPS-1]);
    assign out_q     = st_q[DIV_STEPS-1];
    assign out_pass  = st_p[DIV_STEPS-1];

endmodule

// File: sv/lfows_shape.sv
// back end: cosine lookup with interpolation, easing, rounding and output register
module lfows_shape import lfows_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [DIV_STEPS-1:0] in_q,
    input  pass_t                in_pass,
    output logic                 adv,
    lfows_out_if.source          out_ch
);

    localparam cos_rom_t         COS_ROM  = build_cos_rom();
    localparam logic [COS_AW-1:0] COS_LAST = COS_AW'(COS_DEPTH);
    localparam logic signed [33:0] LIM    = 34'sd1 <<< (SAMPLE_W - 1);
    localparam logic signed [33:0] LIM_M1 = LIM - 34'sd1;
    localparam logic signed [33:0] HALF_LSB = 34'sd1 <<< (30 - SAMPLE_W);

    // stage a: angle fold
    logic [PHASE_W-1:0]  angle;
    logic [29:0]         f30;
    logic [30:0]         g31;
    logic [30:0]         arg;
    logic                a_v_reg;
    mode_t               a_mode_reg;
    val_t                a_base_reg;
    val_t                a_vpre_reg;
    logic [COS_AW-1:0]   a_idx_reg;
    logic [COS_FRAC-1:0] a_frac_reg;
    logic                a_neg_reg;

    // stage b: table read
    logic [COS_AW-1:0]   idx_hi;
    logic                b_v_reg;
    mode_t               b_mode_reg;
    val_t                b_base_reg;
    val_t                b_vpre_reg;
    logic [COS_FRAC-1:0] b_frac_reg;
    logic                b_neg_reg;
    cos_word_t           b_a_reg;
    cos_word_t           b_b_reg;

    // stage c: interpolation product
    logic                b_agb;
    cos_word_t           diff;
    logic [60:0]         iprod;
    logic                c_v_reg;
    mode_t               c_mode_reg;
    val_t                c_base_reg;
    val_t                c_vpre_reg;
    logic                c_neg_reg;
    logic                c_agb_reg;
    cos_word_t           c_a_reg;
    cos_word_t           c_ip_reg;

    // stage d: signed cosine
    cos_word_t           cq;
    val_t                cos_next;
    logic                d_v_reg;
    mode_t               d_mode_reg;
    val_t                d_base_reg;
    val_t                d_vpre_reg;
    val_t                d_cos_reg;

    // stage e: ease and shape value
    val_t                tw;
    val_t                two_e;
    logic [30:0]         ease;
    logic [31:0]         span;
    logic [62:0]         sprod;
    val_t                v_next;
    logic                e_v_reg;
    mode_t               e_mode_reg;
    val_t                e_val_reg;
    logic [31:0]         e_sp_reg;

    // output
    val_t                vf;
    logic signed [33:0]  rs;
    logic signed [33:0]  rc;
    logic                out_v_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    assign adv          = !out_v_reg || out_ch.ready;
    assign out_ch.valid = out_v_reg;
    assign out_ch.sample = sample_reg;

    assign angle = (in_pass.mode == MODE_SINE) ? in_pass.angle : {1'b0, in_q};
    assign f30   = angle[29:0];
    assign g31   = (31'd1 << 30) - {1'b0, f30};
    assign arg   = angle[30] ? g31 : {1'b0, f30};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            e_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg   <= in_valid;
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            d_v_reg   <= c_v_reg;
            e_v_reg   <= d_v_reg;
            out_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mode_reg <= in_pass.mode;
            a_base_reg <= in_pass.base;
            a_vpre_reg <= (in_pass.mode == MODE_LIN)
                          ? in_pass.base - val_t'({2'b0, in_q}) : in_pass.base;
            a_idx_reg  <= arg[30:COS_FRAC];
            a_frac_reg <= arg[COS_FRAC-1:0];
            a_neg_reg  <= angle[31] ^ angle[30];
        end
    end

    assign idx_hi = (a_idx_reg == COS_LAST) ? a_idx_reg : a_idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_a_reg    <= COS_ROM[a_idx_reg];
            b_b_reg    <= COS_ROM[idx_hi];
            b_mode_reg <= a_mode_reg;
            b_base_reg <= a_base_reg;
            b_vpre_reg <= a_vpre_reg;
            b_frac_reg <= a_frac_reg;
            b_neg_reg  <= a_neg_reg;
        end
    end

    assign b_agb = (b_a_reg >= b_b_reg);
    assign diff  = b_agb ? (b_a_reg - b_b_reg) : (b_b_reg - b_a_reg);
    assign iprod = 61'(diff) * 61'({b_frac_reg, {(30-COS_FRAC){1'b0}}});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_ip_reg   <= iprod[60:30];
            c_a_reg    <= b_a_reg;
            c_agb_reg  <= b_agb;
            c_neg_reg  <= b_neg_reg;
            c_mode_reg <= b_mode_reg;
            c_base_reg <= b_base_reg;
            c_vpre_reg <= b_vpre_reg;
        end
    end

    assign cq       = c_agb_reg ? (c_a_reg - c_ip_reg) : (c_a_reg + c_ip_reg);
    assign cos_next = c_neg_reg ? -val_t'({2'b0, cq}) : val_t'({2'b0, cq});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_cos_reg  <= cos_next;
            d_mode_reg <= c_mode_reg;
            d_base_reg <= c_base_reg;
            d_vpre_reg <= c_vpre_reg;
        end
    end

    assign tw    = Q30V - d_cos_reg;
    assign two_e = {tw[32:1], 1'b0};
    assign ease  = tw[31:1];
    assign span  = 32'(d_base_reg + Q30V);
    assign sprod = 63'(ease) * 63'(span);

    always_comb
    begin
        unique case (d_mode_reg)
            MODE_DIRECT:  v_next = d_vpre_reg;
            MODE_LIN:     v_next = d_vpre_reg;
            MODE_SINE:    v_next = d_cos_reg;
            MODE_EASE_UP: v_next = d_base_reg + two_e;
            MODE_EASE_DN: v_next = d_base_reg - two_e;
            MODE_SAW_UP:  v_next = d_base_reg;
            default:      v_next = d_vpre_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_val_reg  <= v_next;
            e_sp_reg   <= sprod[61:30];
            e_mode_reg <= d_mode_reg;
        end
    end

    assign vf = (e_mode_reg == MODE_SAW_UP) ? e_val_reg - val_t'({1'b0, e_sp_reg})
                                            : e_val_reg;
    assign rs = (34'(vf) + HALF_LSB) >>> (31 - SAMPLE_W);

    always_comb
    begin
        priority if (rs > LIM_M1)
        begin
            rc = LIM_M1;
        end
        else if (rs < -LIM_M1)
        begin
            rc = -LIM_M1;
        end
        else
        begin
            rc = rs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sample_reg <= SAMPLE_W'(rc);
        end
    end

endmodule

// File: sv/lfo_waveform_shaper.sv
// top level of the lfo waveform shaper
// Turns one oscillator phase, waveform kind and phase step into one Q1.15 sample per item:
// sine, triangle, eased saw up, eased saw down and eased square, zero for the other kinds.
// One item is taken every clock while the output side keeps up; each result comes out of the
// 31-stage divider that forms the edge ratio and then out of the six stages of cosine lookup,
// interpolation and rounding behind it, which end in the output register. A four-item
// queue sits between the classifying front end and the back end, so either side can stall
// on its own. The edge floor register may be written at any time the block is idle.
module lfo_waveform_shaper import lfows_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    lfows_in_if.sink         in_ch,
    lfows_out_if.source      out_ch,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    logic                 push;
    job_t                 push_job;
    logic                 q_full;
    logic                 q_empty;
    job_t                 head;
    logic                 adv;
    logic                 div_valid;
    logic [DIV_STEPS-1:0] div_q;
    pass_t                div_pass;

    lfows_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    lfows_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (adv),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    lfows_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (!q_empty),
        .in_job    (head),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_pass  (div_pass)
    );

    lfows_shape u_shape (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_q     (div_q),
        .in_pass  (div_pass),
        .adv      (adv),
        .out_ch   (out_ch)
    );

endmodule

// File: verif/lfo_waveform_shaper_tb.sv
// testbench for the lfo waveform shaper: random and directed items checked against a sample predictor
module lfo_waveform_shaper_tb;
    import lfows_pkg::*;

    class sample_scoreboard;
        longint            rom [0:1024];
        longint unsigned   floor_cfg;
        logic signed [15:0] pending [$];
        int                errors;
        int                checked;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          sum;
            for (int i = 0; i <= 1024; i++)
            begin
                x    = (64'd3373259426 * longint'(i)) / 64'd2048;
                x2   = (x * x) >> 30;
                term = 64'd1 << 30;
                sum  = 64'sd1 << 30;
                for (int n = 1; n <= 12; n++)
                begin
                    term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                    begin
                        sum = sum - longint'(term);
                    end
                    else
                    begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0)
                begin
                    sum = 0;
                end
                if (sum > (64'sd1 << 30))
                begin
                    sum = 64'sd1 << 30;
                end
                rom[i] = sum;
            end
            floor_cfg = 1024;
            errors    = 0;
            checked   = 0;
        endfunction

        function longint quarter_cos(longint unsigned f);
            longint unsigned pos;
            longint unsigned idx;
            longint unsigned rem;
            longint unsigned a;
            longint unsigned b;
            pos = f * 1024;
            idx = pos >> 30;
            rem = pos & ((64'd1 << 30) - 1);
            if (idx >= 1024)
            begin
                return rom[1024];
            end
            a = rom[idx];
            b = rom[idx + 1];
            if (a >= b)
            begin
                return longint'(a - (((a - b) * rem) >> 30));
            end
            return longint'(a + (((b - a) * rem) >> 30));
        endfunction

        function longint cos_of_turn(logic [31:0] ang);
            longint unsigned f;
            longint unsigned g;
            f = ang[29:0];
            g = (64'd1 << 30) - f;
            case (ang[31:30])
                2'd0: return quarter_cos(f);
                2'd1: return -quarter_cos(g);
                2'd2: return -quarter_cos(f);
                default: return quarter_cos(g);
            endcase
        endfunction

        function longint unsigned frac_div(longint unsigned n, longint unsigned d, int bits);
            longint unsigned q;
            longint unsigned r;
            q = 0;
            r = n;
            if (d == 0 || n >= d)
            begin
                return (64'd1 << bits) - 1;
            end
            for (int i = 0; i < bits; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        function longint eased(longint unsigned n, longint unsigned d);
            logic [31:0] t;
            t = 32'(frac_div(n, d, 31));
            return ((64'sd1 << 30) - cos_of_turn(t)) / 2;
        endfunction

        function longint unsigned edge_span(longint unsigned frac, longint unsigned mag);
            longint unsigned fw;
            longint unsigned w;
            fw = (floor_cfg * mag) >> 8;
            w  = (frac > fw) ? frac : fw;
            return (w > ONE_CYCLE / 2) ? ONE_CYCLE / 2 : w;
        endfunction

        function longint shaped_value(longint unsigned p, logic [2:0] kind,
                                      longint unsigned mag);
            longint unsigned w;
            longint unsigned half;
            longint          q;
            longint          q30;
            longint          lin_end;
            logic [31:0]     ang;
            half = ONE_CYCLE / 2;
            q30  = 64'sd1 << 30;
            case (kind)
                KIND_SINE:
                begin
                    ang = p[31:0] - 32'h4000_0000;
                    return cos_of_turn(ang);
                end
                KIND_TRIANGLE:
                begin
                    q = longint'((4 * p) >> 2);
                    if (p < ONE_CYCLE / 4)
                    begin
                        return q;
                    end
                    if (p < (ONE_CYCLE / 4) * 3)
                    begin
                        return 2 * q30 - q;
                    end
                    return q - 4 * q30;
                end
                KIND_SAW_UP:
                begin
                    w = edge_span(SAW_FRAC, mag);
                    if (p < ONE_CYCLE - w)
                    begin
                        return longint'((2 * p) >> 2) - q30;
                    end
                    lin_end = longint'((2 * (ONE_CYCLE - w)) >> 2) - q30;
                    q = eased(p - (ONE_CYCLE - w), w);
                    return lin_end - longint'((longint'(unsigned'(q))
                        * longint'(unsigned'(q30 + lin_end))) >>> 30);
                end
                KIND_SAW_DOWN:
                begin
                    w = edge_span(SAW_FRAC, mag);
                    if (p < w)
                    begin
                        return -q30 + 2 * eased(p, w);
                    end
                    return q30 - longint'(frac_div(p - w, ONE_CYCLE - w, 31));
                end
                KIND_SQUARE:
                begin
                    w = edge_span(SQR_FRAC, mag);
                    if (p < half - w)
                    begin
                        return q30;
                    end
                    if (p < half + w)
                    begin
                        return q30 - 2 * eased(p - (half - w), 2 * w);
                    end
                    if (p < ONE_CYCLE - w)
                    begin
                        return -q30;
                    end
                    return -q30 + 2 * eased(p - (ONE_CYCLE - w), w);
                end
                default: return 0;
            endcase
        endfunction

        function void note_item(logic [31:0] phase, logic [2:0] kind, logic [31:0] step);
            longint unsigned mag;
            longint          v;
            longint          s;
            mag = step[31] ? (64'h1_0000_0000 - longint'(step)) : longint'(step);
            v = shaped_value(longint'(phase), kind, mag);
            s = longint'((longint'(v + (64'sd1 << 31)) + (64'sd1 << 14)) >>> 15) - 65536;
            if (s > 32767)
            begin
                s = 32767;
            end
            if (s < -32767)
            begin
                s = -32767;
            end
            pending.push_back(s[15:0]);
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending.size() == 0)
            begin
                $error("sample: none expected, actual %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("sample: expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int   rx_cycle;
    int   stall_cnt;
    int   cfg_writes;
    int   sent;

    lfows_in_if  in_ch ();
    lfows_out_if out_ch ();

    sample_scoreboard sb = new();

    lfo_waveform_shaper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic send_item(logic [31:0] phase, logic [2:0] kind, logic [31:0] step);
        in_ch.valid      <= 1'b1;
        in_ch.phase      <= phase;
        in_ch.kind       <= kind;
        in_ch.phase_step <= step;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_item(phase, kind, step);
        sent++;
    endtask

    task automatic idle_cycles(int n);
        in_ch.valid <= 1'b0;
        repeat (n)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_floor(logic [15:0] value);
        idle_cycles(1);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.floor_cfg = value;
        cfg_writes++;
    endtask

    task automatic random_items(int count);
        logic [31:0] ph;
        logic [31:0] st;
        int          burst;
        int          left;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && left > 0)
            begin
                ph = $urandom();
                case ($urandom_range(0, 4))
                    0: ph = $urandom_range(0, 32'h0FFF_FFFF);
                    1: ph = 32'h8000_0000 + $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
                    2: ph = 32'hFFFF_FFFF - $urandom_range(0, 32'h1FFF_FFFF);
                    default: ;
                endcase
                st = $urandom();
                if ($urandom_range(0, 2) != 0)
                begin
                    st = $urandom_range(0, 32'h00FF_FFFF);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        st = -st;
                    end
                end
                send_item(ph, 3'($urandom_range(0, 7)), st);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 8));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            rx_cycle     <= 0;
            stall_cnt    <= 0;
            out_ch.ready <= 1'b1;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_sample(out_ch.sample);
            end
            if (sent >= 30 && stall_cnt < 300)
            begin
                stall_cnt    <= stall_cnt + 1;
                out_ch.ready <= 1'b0;
            end
            else if (((rx_cycle / 97) % 3) == 0)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin
        #(12 * 300000);
        $display("lfo_waveform_shaper_tb: errors");
        $finish;
    end

    initial
    begin
        logic [31:0] dphase [6];
        logic [31:0] dstep  [4];
        logic [15:0] floors [5];
        cfg_writes       = 0;
        sent             = 0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.phase      = '0;
        in_ch.kind       = '0;
        in_ch.phase_step = '0;
        dphase = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000,
                   32'hC000_0000, 32'h7FFF_FFFF};
        dstep  = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        floors = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'h0000};
        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < 8; k++)
        begin
            send_item(dphase[k % 6], 3'(k), dstep[k % 4]);
        end
        for (int k = 0; k < 12; k++)
        begin
            send_item(dphase[k % 6], (k % 3 == 0) ? KIND_SQUARE :
                      (k % 3 == 1) ? KIND_SAW_UP : KIND_SAW_DOWN, dstep[k % 4]);
        end
        random_items(120);
        floors[4] = 16'($urandom());
        for (int f = 0; f < 5; f++)
        begin
            write_floor(floors[f]);
            send_item(32'hFFFF_FFFF, KIND_SAW_UP, 32'h8000_0000);
            send_item(32'h7FFF_FFFF, KIND_SQUARE, 32'h0000_1000);
            random_items(100);
        end
        idle_cycles(1);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60)
        begin
            @(posedge clk);
        end
        $display("run covered %0d items, %0d samples checked, %0d floor settings",
                 sent, sb.checked, cfg_writes);
        $display("all waveform kinds, edge extremes and a long output stall included");
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("lfo_waveform_shaper_tb: clean");
        end
        else
        begin
            $display("lfo_waveform_shaper_tb: errors");
        end
        $finish;
    end
endmodule

// File: files.f
sv/lfows_pkg.sv
sv/lfows_in_if.sv
sv/lfows_out_if.sv
sv/lfows_front.sv
sv/lfows_queue.sv
sv/lfows_div.sv
sv/lfows_shape.sv
sv/lfo_waveform_shaper.sv
verif/lfo_waveform_shaper_tb.sv
